// ----- rtl/utf8sdc_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8sdc_pkg
// Shared types, field widths and decode constants for the UTF-8 stream
// decoder with code point and character counters.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8sdc_pkg;

    // field widths
    localparam int BYTE_W     = 8;
    localparam int CP_W       = 21;
    localparam int LEN_W      = 3;
    localparam int PEND_W     = 2;
    localparam int OUT_CNT_W  = 16;

    // default width of the offset and counter registers
    localparam int COUNT_BITS_DEFAULT = 16;

    // payload masks for continuation and lead bytes
    localparam logic [BYTE_W-1:0] MASK_CONT  = 8'h3f;
    localparam logic [BYTE_W-1:0] MASK_TWO   = 8'h1f;
    localparam logic [BYTE_W-1:0] MASK_THREE = 8'h0f;
    localparam logic [BYTE_W-1:0] MASK_FOUR  = 8'h07;
    localparam logic [BYTE_W-1:0] MASK_ONE   = 8'h7f;

    // top bits of a continuation byte, and lead byte high nibbles
    localparam logic [1:0] CONT_TAG     = 2'b10;
    localparam logic [3:0] NIB_TWO_LO   = 4'hc;
    localparam logic [3:0] NIB_THREE    = 4'he;
    localparam logic [3:0] NIB_FOUR     = 4'hf;

    // sequence lengths
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    // combining mark ranges, lower bound inclusive, upper bound exclusive
    localparam logic [CP_W-1:0] MARK0_LO = 21'h00300;
    localparam logic [CP_W-1:0] MARK0_HI = 21'h00370;
    localparam logic [CP_W-1:0] MARK1_LO = 21'h01ab0;
    localparam logic [CP_W-1:0] MARK1_HI = 21'h01b00;
    localparam logic [CP_W-1:0] MARK2_LO = 21'h01dc0;
    localparam logic [CP_W-1:0] MARK2_HI = 21'h01e00;
    localparam logic [CP_W-1:0] MARK3_LO = 21'h020d0;
    localparam logic [CP_W-1:0] MARK3_HI = 21'h02100;
    localparam logic [CP_W-1:0] MARK4_LO = 21'h0fe20;
    localparam logic [CP_W-1:0] MARK4_HI = 21'h0fe30;

    // one input item held in the input register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data_byte;
        logic              string_start;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic [OUT_CNT_W-1:0] character_total;
        logic [OUT_CNT_W-1:0] codepoint_total;
        logic [OUT_CNT_W-1:0] start_offset;
        logic                 bad_start;
        logic                 is_diacritic;
        logic [LEN_W-1:0]     sequence_length;
        logic [CP_W-1:0]      code_point;
    } result_t;

    // combining diacritic range check
    function automatic logic is_mark(input logic [CP_W-1:0] v);
        is_mark = (v >= MARK0_LO && v < MARK0_HI) ||
                  (v >= MARK1_LO && v < MARK1_HI) ||
                  (v >= MARK2_LO && v < MARK2_HI) ||
                  (v >= MARK3_LO && v < MARK3_HI) ||
                  (v >= MARK4_LO && v < MARK4_HI);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/utf8sdc_in_stage.sv -----
// ----------------------------------------------------------------------------
// utf8sdc_in_stage
// Input register: holds one accepted byte until the decode stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sdc_in_stage
    import utf8sdc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,  // data_byte
    input  wire logic [0:0]        s_tuser,  // string_start
    input  wire logic              take,
    output in_item_t               item
);

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              start_reg;
    logic              load;

    // room when empty or when the held byte moves on this cycle
    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= s_tdata;
            start_reg <= s_tuser[0];
        end
    end

    assign item.valid        = valid_reg;
    assign item.data_byte    = byte_reg;
    assign item.string_start = start_reg;

endmodule

`default_nettype wire

// ----- rtl/utf8sdc_core.sv -----
// ----------------------------------------------------------------------------
// utf8sdc_core
// Decode state, per-byte decode logic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sdc_core
    import utf8sdc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  in_item_t      item,
    output logic          take,
    output logic          res_valid,
    input  wire logic     res_ready,
    output result_t       res
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // decode state
    logic [PEND_W-1:0]     pend_reg,    pend_next;
    logic [LEN_W-1:0]      len_reg,     len_next;
    logic [CP_W-1:0]       partial_reg, partial_next;
    logic [COUNT_BITS-1:0] pos_reg,     pos_next;
    logic [COUNT_BITS-1:0] sstart_reg,  sstart_next;
    logic [COUNT_BITS-1:0] cp_cnt_reg,  cp_cnt_next;
    logic [COUNT_BITS-1:0] ch_cnt_reg,  ch_cnt_next;

    // result register
    logic    out_valid_reg;
    result_t out_reg;
    logic    has_result;
    result_t res_next;

    // state as seen by this byte, after an optional string start clear
    logic [PEND_W-1:0]     pend_cur;
    logic [LEN_W-1:0]      len_cur;
    logic [CP_W-1:0]       partial_cur;
    logic [COUNT_BITS-1:0] pos_cur;
    logic [COUNT_BITS-1:0] sstart_cur;
    logic [COUNT_BITS-1:0] cp_cnt_cur;
    logic [COUNT_BITS-1:0] ch_cnt_cur;

    logic [BYTE_W-1:0] b;
    logic [CP_W-1:0]   cont_ext;
    logic [PEND_W-1:0] pend_dec;
    logic              done;
    logic              bad;
    logic              mark;

    // advance when a byte is held and the result slot is free or draining
    assign take = item.valid && (!out_valid_reg || res_ready);

    assign b           = item.data_byte;
    assign pend_cur    = item.string_start ? '0 : pend_reg;
    assign len_cur     = item.string_start ? '0 : len_reg;
    assign partial_cur = item.string_start ? '0 : partial_reg;
    assign pos_cur     = item.string_start ? '0 : pos_reg;
    assign sstart_cur  = item.string_start ? '0 : sstart_reg;
    assign cp_cnt_cur  = item.string_start ? '0 : cp_cnt_reg;
    assign ch_cnt_cur  = item.string_start ? '0 : ch_cnt_reg;

    assign pend_dec = pend_cur - 1'b1;
    assign cont_ext = {{(CP_W-BYTE_W){1'b0}}, b & MASK_CONT};

    // byte decode and state update
    always_comb
    begin
        pend_next    = pend_cur;
        len_next     = len_cur;
        partial_next = partial_cur;
        sstart_next  = sstart_cur;
        pos_next     = (pos_cur == CNT_MAX) ? pos_cur : pos_cur + 1'b1;
        done         = 1'b0;
        bad          = 1'b0;

        if (pend_cur != '0)
        begin
            // continuation inside a sequence, placed by bytes still to come
            pend_next = pend_dec;
            case (pend_dec)
                2'd2:    partial_next = partial_cur | (cont_ext << 12);
                2'd1:    partial_next = partial_cur | (cont_ext << 6);
                default: partial_next = partial_cur | cont_ext;
            endcase
            done = (pend_dec == '0);
        end
        else if (b[7:6] == CONT_TAG)
        begin
            // stray continuation byte
            bad = 1'b1;
        end
        else
        begin
            // lead byte
            sstart_next = pos_cur;
            if (b[7:4] == NIB_FOUR)
            begin
                len_next     = LEN_FOUR;
                pend_next    = 2'd3;
                partial_next = {{(CP_W-BYTE_W){1'b0}}, b & MASK_FOUR} << 18;
            end
            else if (b[7:4] == NIB_THREE)
            begin
                len_next     = LEN_THREE;
                pend_next    = 2'd2;
                partial_next = {{(CP_W-BYTE_W){1'b0}}, b & MASK_THREE} << 12;
            end
            else if (b[7:4] >= NIB_TWO_LO)
            begin
                len_next     = LEN_TWO;
                pend_next    = 2'd1;
                partial_next = {{(CP_W-BYTE_W){1'b0}}, b & MASK_TWO} << 6;
            end
            else
            begin
                len_next     = LEN_ONE;
                pend_next    = 2'd0;
                partial_next = {{(CP_W-BYTE_W){1'b0}}, b & MASK_ONE};
                done         = 1'b1;
            end
        end
    end

    // counters and result fields
    assign mark = is_mark(partial_next);

    always_comb
    begin
        cp_cnt_next = cp_cnt_cur;
        ch_cnt_next = ch_cnt_cur;
        if (done)
        begin
            cp_cnt_next = (cp_cnt_cur == CNT_MAX) ? cp_cnt_cur : cp_cnt_cur + 1'b1;
            if (!mark)
            begin
                ch_cnt_next = (ch_cnt_cur == CNT_MAX) ? ch_cnt_cur : ch_cnt_cur + 1'b1;
            end
        end
    end

    assign has_result = done || bad;

    always_comb
    begin
        res_next.code_point      = bad ? '0 : partial_next;
        res_next.sequence_length = bad ? '0 : len_next;
        res_next.is_diacritic    = bad ? 1'b0 : mark;
        res_next.bad_start       = bad;
        res_next.start_offset    = bad ? OUT_CNT_W'(pos_cur) : OUT_CNT_W'(sstart_next);
        res_next.codepoint_total = OUT_CNT_W'(cp_cnt_next);
        res_next.character_total = OUT_CNT_W'(ch_cnt_next);
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= '0;
            len_reg     <= '0;
            partial_reg <= '0;
            pos_reg     <= '0;
            sstart_reg  <= '0;
            cp_cnt_reg  <= '0;
            ch_cnt_reg  <= '0;
        end
        else if (take)
        begin
            pend_reg    <= pend_next;
            len_reg     <= len_next;
            partial_reg <= partial_next;
            pos_reg     <= pos_next;
            sstart_reg  <= sstart_next;
            cp_cnt_reg  <= cp_cnt_next;
            ch_cnt_reg  <= ch_cnt_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= has_result;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take && has_result)
        begin
            out_reg <= res_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

// ----- rtl/utf8_stream_decoder_counter.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder_counter
// UTF-8 byte stream decoder emitting code points with offsets, a combining
// mark flag and saturating code point and character totals.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                         tuser
//  s_*      in   data_byte[7:0]                             string_start
//  m_*      out  code_point[20:0] sequence_length[23:21]    is_diacritic[0]
//                start_offset[39:24] codepoint_total[55:40] bad_start[1]
//                character_total[71:56]
//
//  one byte per cycle sustained while m_tready does not stall; after its last
//  byte is accepted a result passes the input register, then the result register
//  bytes inside a sequence and bytes that finish nothing give no transaction
//  rst_n clears the decode state, offset, counters and both valid flags
//  a stall on m_tready holds the result and backs up through the input register
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder_counter
    import utf8sdc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic [0:0]  s_tuser,   // string_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // code_point, sequence_length,
                                        // start_offset, codepoint_total,
                                        // character_total
    output logic [1:0]       m_tuser    // is_diacritic, bad_start
);

    in_item_t item;
    logic     take;
    result_t  res;

    // input register
    utf8sdc_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .take     (take),
        .item     (item)
    );

    // decode and result register
    utf8sdc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .take      (take),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // output packing
    assign m_tdata = {res.character_total, res.codepoint_total, res.start_offset,
                      res.sequence_length, res.code_point};
    assign m_tuser = {res.bad_start, res.is_diacritic};

endmodule

`default_nettype wire

// ----- tb/utf8_decode_checker.sv -----
// ----------------------------------------------------------------------------
// utf8_decode_checker
// Passive scoreboard for the UTF-8 stream decoder. It decodes every byte
// accepted on the input stream on its own, queues the result each completed
// sequence or stray continuation byte should give, and compares each output
// transaction field by field with the oldest queued result.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_decode_checker
    import utf8sdc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic [0:0]  s_tuser,   // string_start
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [71:0] m_tdata,   // code_point, sequence_length,
                                        // start_offset, codepoint_total,
                                        // character_total
    input  wire logic [1:0]  m_tuser,   // is_diacritic, bad_start
    output int               fail_count,
    output int               waiting
);

    localparam logic [OUT_CNT_W-1:0] COUNT_TOP = '1;

    // decoder state as the design should hold it
    logic [PEND_W-1:0]    cont_left;
    logic [LEN_W-1:0]     seq_len;
    logic [CP_W-1:0]      cp_acc;
    logic [OUT_CNT_W-1:0] byte_pos;
    logic [OUT_CNT_W-1:0] seq_pos;
    logic [OUT_CNT_W-1:0] cp_total;
    logic [OUT_CNT_W-1:0] char_total;

    // decoded results still owed by the design, oldest first
    result_t decoded_q[$];

    function automatic logic [OUT_CNT_W-1:0] bump(input logic [OUT_CNT_W-1:0] v);
        return (v == COUNT_TOP) ? v : v + 1'b1;
    endfunction

    task automatic clear_state();
        cont_left  = '0;
        seq_len    = '0;
        cp_acc     = '0;
        byte_pos   = '0;
        seq_pos    = '0;
        cp_total   = '0;
        char_total = '0;
    endtask

    // one accepted byte: advance the decode and queue any result it finishes
    task automatic decode_byte(input logic [7:0] b, input logic restart);
        result_t              r;
        logic                 done;
        logic [OUT_CNT_W-1:0] here;
        logic [LEN_W-1:0]     len;
        logic [CP_W-1:0]      bits;
        r    = '0;
        done = 1'b0;
        if (restart)
        begin
            clear_state();
        end
        here     = byte_pos;
        byte_pos = bump(byte_pos);

        if (cont_left != 0)
        begin
            // inside a sequence any byte counts as a continuation
            cont_left = cont_left - 1'b1;
            cp_acc    = cp_acc | (CP_W'(b & MASK_CONT) << (6 * cont_left));
            done      = (cont_left == 0);
        end
        else if (b[7:6] == CONT_TAG)
        begin
            // continuation with no lead: error result, counters unchanged
            r.bad_start       = 1'b1;
            r.start_offset    = here;
            r.codepoint_total = cp_total;
            r.character_total = char_total;
            decoded_q.push_back(r);
        end
        else
        begin
            // lead byte, length from the high nibble
            if (b[7:4] == NIB_FOUR)
            begin
                len  = LEN_FOUR;
                bits = CP_W'(b & MASK_FOUR);
            end
            else if (b[7:4] == NIB_THREE)
            begin
                len  = LEN_THREE;
                bits = CP_W'(b & MASK_THREE);
            end
            else if (b[7:4] >= NIB_TWO_LO)
            begin
                len  = LEN_TWO;
                bits = CP_W'(b & MASK_TWO);
            end
            else
            begin
                len  = LEN_ONE;
                bits = CP_W'(b & MASK_ONE);
            end
            seq_len   = len;
            seq_pos   = here;
            cont_left = PEND_W'(len - 1);
            cp_acc    = bits << (6 * (len - 1));
            done      = (len == LEN_ONE);
        end

        if (done)
        begin
            r.is_diacritic = (cp_acc >= MARK0_LO && cp_acc < MARK0_HI) ||
                             (cp_acc >= MARK1_LO && cp_acc < MARK1_HI) ||
                             (cp_acc >= MARK2_LO && cp_acc < MARK2_HI) ||
                             (cp_acc >= MARK3_LO && cp_acc < MARK3_HI) ||
                             (cp_acc >= MARK4_LO && cp_acc < MARK4_HI);
            cp_total = bump(cp_total);
            if (!r.is_diacritic)
            begin
                char_total = bump(char_total);
            end
            r.code_point      = cp_acc;
            r.sequence_length = seq_len;
            r.start_offset    = seq_pos;
            r.codepoint_total = cp_total;
            r.character_total = char_total;
            decoded_q.push_back(r);
        end
    endtask

    task automatic check_field(input string what, input logic [CP_W-1:0] want,
                               input logic [CP_W-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            clear_state();
            decoded_q.delete();
        end
        else
        begin
            // output transaction against the oldest owed result
            if (m_tvalid && m_tready)
            begin
                if (decoded_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with none owed, expected nothing, actual %h/%h",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("code_point", want.code_point, m_tdata[20:0]);
                    check_field("sequence_length", CP_W'(want.sequence_length),
                                CP_W'(m_tdata[23:21]));
                    check_field("start_offset", CP_W'(want.start_offset),
                                CP_W'(m_tdata[39:24]));
                    check_field("codepoint_total", CP_W'(want.codepoint_total),
                                CP_W'(m_tdata[55:40]));
                    check_field("character_total", CP_W'(want.character_total),
                                CP_W'(m_tdata[71:56]));
                    check_field("is_diacritic", CP_W'(want.is_diacritic), CP_W'(m_tuser[0]));
                    check_field("bad_start", CP_W'(want.bad_start), CP_W'(m_tuser[1]));
                end
            end
            // input transaction
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata, s_tuser[0]);
            end
        end
        waiting = decoded_q.size();
    end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the UTF-8 stream decoder. A short directed byte
// run covers the lead classes, stray continuations, oversized leads and a
// restart inside a sequence; random streams of mostly well formed sequences
// follow under changing idle patterns, then one unbroken string of mostly
// ascii with a few marks and stray continuations. A separate checker does
// all comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import utf8sdc_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_START    = 40;
    localparam int HOLD_LEN      = 250;
    localparam int PHASE_BYTES   = 260;
    localparam int SAT_RUN       = 50;
    localparam int DRAIN_MAX     = 5000;
    localparam int TAIL_CYCLES   = 8;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // data_byte
    logic [0:0]  s_tuser  = '0;    // string_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;          // code_point, sequence_length, start_offset,
                                   // codepoint_total, character_total
    logic [1:0]  m_tuser;          // is_diacritic, bad_start

    int tx_idle_pct = 17;
    int rx_idle_pct = 65;
    int bytes_sent  = 0;
    int cycle_count = 0;
    int rx_cycle    = 0;
    int fail_count;
    int waiting;

    logic [8:0] opening [0:24];    // {string_start, data_byte}

    utf8_stream_decoder_counter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    utf8_decode_checker decode_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .waiting    (waiting)
    );

    // clock, period 12
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run limit reached", $time);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off early in the run
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle++;
        end
        if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // one input transaction, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic restart);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= restart;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        bytes_sent++;
    endtask

    // continuation byte, now and then with a non-standard tag
    function automatic logic [7:0] cont_byte(input logic [5:0] payload);
        if ($urandom_range(0, 7) == 0)
        begin
            return {2'($urandom), payload};
        end
        return {CONT_TAG, payload};
    endfunction

    // encode a code point in the given length; four-byte leads span F0-FF
    task automatic send_code_point(input logic [CP_W-1:0] cp, input logic [LEN_W-1:0] len,
                                   input logic restart);
        logic [7:0] lead;
        int         i;
        case (len)
            LEN_ONE:   lead = {1'b0, cp[6:0]};
            LEN_TWO:   lead = {3'b110, cp[10:6]};
            LEN_THREE: lead = {NIB_THREE, cp[15:12]};
            default:   lead = {NIB_FOUR, 1'($urandom), cp[20:18]};
        endcase
        send_byte(lead, restart);
        for (i = int'(len) - 2; i >= 0; i--)
        begin
            send_byte(cont_byte(6'(cp >> (6 * i))), 1'b0);
        end
    endtask

    // mostly well formed sequences, some noise and cut-off sequences
    task automatic random_stream(input int n);
        int               stop;
        int               pick;
        int               lo;
        int               hi;
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
        logic             restart;
        stop = bytes_sent + n;
        while (bytes_sent < stop)
        begin
            pick    = $urandom_range(0, 99);
            restart = ($urandom_range(0, 31) == 0);
            if (pick < 3)
            begin
                send_byte(8'($urandom), restart);
            end
            else if (pick < 7)
            begin
                // stray continuation
                send_byte({CONT_TAG, 6'($urandom)}, restart);
            end
            else if (pick < 11)
            begin
                // lead cut short by a string restart
                send_byte(8'($urandom_range(8'hc0, 8'hff)), restart);
                if ($urandom_range(0, 1))
                begin
                    send_byte(cont_byte(6'($urandom)), 1'b0);
                end
                send_byte({1'b0, 7'($urandom)}, 1'b1);
            end
            else if (pick < 31)
            begin
                // around the combining mark ranges, edges favored
                case ($urandom_range(0, 4))
                    0:       begin lo = int'(MARK0_LO); hi = int'(MARK0_HI); end
                    1:       begin lo = int'(MARK1_LO); hi = int'(MARK1_HI); end
                    2:       begin lo = int'(MARK2_LO); hi = int'(MARK2_HI); end
                    3:       begin lo = int'(MARK3_LO); hi = int'(MARK3_HI); end
                    default: begin lo = int'(MARK4_LO); hi = int'(MARK4_HI); end
                endcase
                case ($urandom_range(0, 5))
                    0:       cp = CP_W'(lo - 1);
                    1:       cp = CP_W'(lo);
                    2:       cp = CP_W'(hi - 1);
                    3:       cp = CP_W'(hi);
                    default: cp = CP_W'($urandom_range(lo - 2, hi + 1));
                endcase
                len = (cp < 21'h800) ? LEN_TWO : LEN_THREE;
                if ($urandom_range(0, 7) == 0)
                begin
                    len = LEN_FOUR;
                end
                send_code_point(cp, len, restart);
            end
            else if (pick < 51)
            begin
                send_code_point(CP_W'($urandom_range(0, 8'h7f)), LEN_ONE, restart);
            end
            else if (pick < 71)
            begin
                send_code_point(CP_W'($urandom_range(0, 12'h7ff)), LEN_TWO, restart);
            end
            else if (pick < 86)
            begin
                send_code_point(CP_W'($urandom_range(0, 16'hffff)), LEN_THREE, restart);
            end
            else
            begin
                send_code_point(CP_W'($urandom), LEN_FOUR, restart);
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int pick;
        int drain;
        opening = '{
            9'h100, 9'h07f,                 // ascii extremes, first opens the string
            9'h080, 9'h0bf,                 // continuations with no lead
            9'h0c2, 9'h0a9,                 // two bytes
            9'h0cc, 9'h080,                 // first combining mark
            9'h0df, 9'h0bf,                 // top two-byte lead
            9'h0c0, 9'h080,                 // overlong zero
            9'h0e2, 9'h083, 9'h090,         // mark in the symbol range
            9'h0f0, 9'h09f, 9'h098, 9'h080, // four bytes
            9'h0ff, 9'h0ff, 9'h000, 9'h07f, // oversized lead, odd continuations
            9'h0e2, 9'h141                  // restart inside a sequence
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed opening, then the three idle patterns
        foreach (opening[i])
        begin
            send_byte(opening[i][7:0], opening[i][8]);
        end
        random_stream(PHASE_BYTES);
        tx_idle_pct = 65;
        rx_idle_pct = 17;
        random_stream(PHASE_BYTES);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_stream(PHASE_BYTES);

        // one unbroken string of mostly ascii, a few marks and stray continuations
        send_byte(8'h41, 1'b1);
        repeat (SAT_RUN)
        begin
            pick = $urandom_range(0, 63);
            if (pick == 0)
            begin
                send_code_point(CP_W'($urandom_range(int'(MARK0_LO), int'(MARK0_HI) - 1)),
                                LEN_TWO, 1'b0);
            end
            else if (pick == 1)
            begin
                send_byte({CONT_TAG, 6'($urandom)}, 1'b0);
            end
            else
            begin
                send_byte({1'b0, 7'($urandom)}, 1'b0);
            end
        end
        random_stream(40);
        s_tvalid <= 1'b0;

        // let the owed results drain
        drain = 0;
        while (waiting != 0 && drain < DRAIN_MAX)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(negedge clk);

        if (waiting != 0)
        begin
            $display("%0t: %0d decoded results never arrived", $time, waiting);
        end
        if (fail_count == 0 && waiting == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/utf8sdc_pkg.sv
rtl/utf8sdc_in_stage.sv
rtl/utf8sdc_core.sv
rtl/utf8_stream_decoder_counter.sv
tb/utf8_decode_checker.sv
tb/tb.sv
